[design/ktslc_pkg.sv]
// Shared types and constants for the keyed tag/stage lookup cache.
package ktslc_pkg;

  // Default sizing of the slot table.
  localparam int SLOT_COUNT_DEF = 64;
  localparam int STAMP_BITS_DEF = 32;
  localparam int TAG_BITS_DEF   = 4;

  // The slot hash drops the low key nibble.
  localparam int HASH_SHIFT = 4;

  // Stage value that means no stage.
  localparam logic [8:0] STAGE_NONE = 9'h1FF;

  // Request kinds carried in tuser.
  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Where an answer came from.
  typedef enum logic [2:0] {
    SRC_NULL       = 3'd0,
    SRC_BACKING    = 3'd1,
    SRC_HOT_PART   = 3'd2,
    SRC_PART_SLOT  = 3'd3,
    SRC_PART_SCAN  = 3'd4,
    SRC_HOT_SCENE  = 3'd5,
    SRC_SCENE_SLOT = 3'd6,
    SRC_SCENE_SCAN = 3'd7
  } source_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_VSCAN,
    ST_TOUCH,
    ST_HALVE,
    ST_WRITE,
    ST_FINISH
  } state_t;

endpackage

[design/keyed_tag_stage_lookup_cache_unit.sv]
// Top level of the keyed tag/stage lookup cache with its slot memory and sequencer.
//
// Usage: a request item enters on the s_axis channel; tuser selects query or
// clear. Each query yields exactly one answer item on the m_axis channel; a
// clear yields none. The one-bit cache_enable register is written over the
// cfg channel (cfg_ready is always high); the user must write it only while
// the block is idle, as the block itself does not enforce this. A null
// request, a disabled cache or a hot-part hit answers without touching the
// slot memory. A slot hit is sought in passes over the slot memory, part keys
// first, then scene keys; a miss adds a victim pass. When the use clock
// wraps, a stamp halving pass is added. The slot memory has a single read
// port, read once a cycle. One item is worked on at a time; s_axis_tready
// is high only while the sequencer is idle, and the next item is taken while
// an answer still waits in the output register.
// Reset: all slots invalid, hot registers empty, use clock zero, cache on.
// A stalled receiver holds the answer in the output register; the block stops
// before loading a following answer until that one is taken.
module keyed_tag_stage_lookup_cache_unit
  import ktslc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write: cache_enable in bit 0.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,
  // Request: tdata from bit 0 up: part_key[63:0], scene_key[127:64],
  // stage_hint[136:128], render_stage[145:137], fill_resolved[146],
  // fill_tag[150:147], fill_stage[159:151].
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  // tuser: func (0 query, 1 clear).
  input  logic         s_axis_tuser,
  // Answer: tdata from bit 0 up: resolved[0], tag[4:1], stage[13:5],
  // source[16:14], zero fill[23:17].
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 2);
  localparam logic [AW-1:0] HASH_MASK = AW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] LAST_POS  = CW'(SLOT_COUNT);

  typedef struct packed {
    logic [63:0]           part;
    logic [63:0]           scene;
    logic                  res;
    logic [TAG_BITS-1:0]   tag;
    logic [8:0]            stage;
    logic [STAMP_BITS-1:0] stamp;
  } rec_t;

  function automatic logic [AW-1:0] hash_slot(input logic [63:0] k);
    return k[HASH_SHIFT +: AW] & HASH_MASK;
  endfunction

  function automatic logic [3:0] tag4(input logic [TAG_BITS-1:0] t);
    logic [11:0] w;
    w = 12'(t);
    return w[3:0];
  endfunction

  // Slot memory and its registered read port.
  rec_t mem [SLOT_COUNT];
  rec_t rdata;
  logic rd_en, we;
  logic [AW-1:0] raddr, waddr;
  rec_t wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Control and datapath registers.
  state_t state, state_next;
  logic cache_enable;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [STAMP_BITS-1:0] use_clock;
  logic [STAMP_BITS-1:0] uc_inc;
  logic q_func, q_fres;
  logic [63:0] q_part, q_scene;
  logic [8:0] q_hint, q_rstage, q_fstage;
  logic [TAG_BITS-1:0] q_ftag;
  logic hp_valid, hp_res, hs_valid, hs_res;
  logic [63:0] hp_key, hs_key;
  logic [TAG_BITS-1:0] hp_tag, hs_tag;
  logic [8:0] hp_stage, hs_stage;
  logic [CW-1:0] pos, pos_m1;
  logic [AW-1:0] pos_lo, pos_a;
  logic chk_v, chk_skip, chk_hash, scan_scene;
  logic [AW-1:0] chk_addr, tgt, hsh;
  logic [STAMP_BITS-1:0] best;
  rec_t rec;
  source_t rec_src;
  logic pend_res;
  logic [3:0] pend_tag;
  logic [8:0] pend_stage;
  source_t pend_src;
  logic [8:0] cur;
  logic chk_match, hp_hit, hs_hit, scan_end;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  assign cur    = q_hint[8] ? q_rstage : q_hint;
  assign uc_inc = use_clock + 1'b1;
  assign pos_m1 = pos - 1'b1;
  assign pos_lo = pos[AW-1:0];
  assign pos_a  = pos_m1[AW-1:0];
  assign hsh    = scan_scene ? hash_slot(q_scene) : hash_slot(q_part);
  assign hp_hit = hp_valid && (hp_key == q_part);
  assign hs_hit = hs_valid && (hs_key == q_scene) && (cur[8] || hs_stage == cur);
  assign scan_end = !chk_v && (pos > LAST_POS);

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    raddr      = pos_lo;
    we         = 1'b0;
    waddr      = tgt;
    wdata      = rec;
    chk_match  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (q_func == FUNC_CLEAR) begin
          state_next = ST_IDLE;
        end else if (q_part == '0 || !cache_enable || hp_hit) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pos <= LAST_POS) begin
          rd_en = 1'b1;
          raddr = (pos == '0) ? hsh : pos_a;
        end
        chk_match = chk_v && !chk_skip && slot_valid[chk_addr] &&
                    (scan_scene ? (rdata.scene == q_scene &&
                                   (cur[8] || rdata.stage == cur))
                                : (rdata.part == q_part));
        if (chk_match) begin
          state_next = ST_TOUCH;
        end else if (scan_end) begin
          if (!scan_scene && q_scene != '0) begin
            state_next = hs_hit ? ST_FINISH : ST_SCAN;
          end else begin
            state_next = ST_VSCAN;
          end
        end
      end
      ST_VSCAN: begin
        if (pos < LAST_POS) begin
          rd_en = 1'b1;
        end
        if ((chk_v && !slot_valid[chk_addr]) || (!chk_v && pos >= LAST_POS)) begin
          state_next = ST_TOUCH;
        end
      end
      ST_TOUCH: begin
        state_next = (uc_inc == '0) ? ST_HALVE : ST_WRITE;
      end
      ST_HALVE: begin
        if (pos < LAST_POS) begin
          rd_en = 1'b1;
        end
        if (pos != '0) begin
          we          = 1'b1;
          waddr       = pos_a;
          wdata       = rdata;
          wdata.stamp = rdata.stamp >> 1;
        end
        if (pos == LAST_POS) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        we          = 1'b1;
        wdata.stamp = use_clock;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b1;
    end else if (cfg_valid) begin
      cache_enable <= cfg_data;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      use_clock  <= '0;
      hp_valid   <= 1'b0;
      hs_valid   <= 1'b0;
      chk_v      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            q_func   <= s_axis_tuser;
            q_part   <= s_axis_tdata[63:0];
            q_scene  <= s_axis_tdata[127:64];
            q_hint   <= s_axis_tdata[136:128];
            q_rstage <= s_axis_tdata[145:137];
            q_fres   <= s_axis_tdata[146];
            q_ftag   <= TAG_BITS'(s_axis_tdata[150:147]);
            q_fstage <= s_axis_tdata[159:151];
          end
        end
        ST_DISPATCH: begin
          pos        <= '0;
          chk_v      <= 1'b0;
          scan_scene <= 1'b0;
          if (q_func == FUNC_CLEAR) begin
            slot_valid <= '0;
            use_clock  <= '0;
            hp_valid   <= 1'b0;
            hs_valid   <= 1'b0;
          end else if (q_part == '0) begin
            pend_res   <= 1'b0;
            pend_tag   <= '0;
            pend_stage <= STAGE_NONE;
            pend_src   <= SRC_NULL;
          end else if (!cache_enable) begin
            pend_res   <= q_fres;
            pend_tag   <= tag4(q_ftag);
            pend_stage <= q_fstage;
            pend_src   <= SRC_BACKING;
          end else begin
            pend_res   <= hp_res;
            pend_tag   <= tag4(hp_tag);
            pend_stage <= hp_stage;
            pend_src   <= SRC_HOT_PART;
          end
        end
        ST_SCAN: begin
          // One read issued and one slot checked per cycle.
          if (pos <= LAST_POS) begin
            pos <= pos + 1'b1;
          end
          chk_v    <= (pos <= LAST_POS);
          chk_addr <= raddr;
          chk_skip <= (pos != '0) && (raddr == hsh);
          chk_hash <= (pos == '0);
          if (chk_match) begin
            rec      <= rdata;
            rec.part <= q_part;
            tgt      <= chk_addr;
            if (scan_scene) begin
              rec_src <= chk_hash ? SRC_SCENE_SLOT : SRC_SCENE_SCAN;
            end else begin
              rec_src <= chk_hash ? SRC_PART_SLOT : SRC_PART_SCAN;
            end
          end else if (scan_end) begin
            pos   <= '0;
            chk_v <= 1'b0;
            if (!scan_scene && q_scene != '0) begin
              scan_scene <= 1'b1;
              if (hs_hit) begin
                hp_valid   <= 1'b1;
                hp_key     <= q_part;
                hp_res     <= hs_res;
                hp_tag     <= hs_tag;
                hp_stage   <= hs_stage;
                pend_res   <= hs_res;
                pend_tag   <= tag4(hs_tag);
                pend_stage <= hs_stage;
                pend_src   <= SRC_HOT_SCENE;
              end
            end
          end
        end
        ST_VSCAN: begin
          // Victim search: first invalid slot, else the least stamp.
          if (pos < LAST_POS) begin
            pos <= pos + 1'b1;
          end
          chk_v     <= (pos < LAST_POS);
          chk_addr  <= pos_lo;
          rec.part  <= q_part;
          rec.scene <= q_scene;
          rec.res   <= q_fres;
          rec.tag   <= q_fres ? q_ftag : '0;
          rec.stage <= q_fres ? q_fstage : STAGE_NONE;
          rec_src   <= SRC_BACKING;
          if (chk_v) begin
            if (!slot_valid[chk_addr]) begin
              tgt <= chk_addr;
            end else if (chk_addr == '0 || rdata.stamp < best) begin
              tgt  <= chk_addr;
              best <= rdata.stamp;
            end
          end
        end
        ST_TOUCH: begin
          use_clock <= (uc_inc == '0) ? STAMP_BITS'(1) : uc_inc;
          pos       <= '0;
        end
        ST_HALVE: begin
          pos <= pos + 1'b1;
        end
        ST_WRITE: begin
          slot_valid[tgt] <= 1'b1;
          hp_valid <= 1'b1;
          hp_key   <= q_part;
          hp_res   <= rec.res;
          hp_tag   <= rec.tag;
          hp_stage <= rec.stage;
          if (rec_src == SRC_BACKING || rec_src == SRC_SCENE_SLOT ||
              rec_src == SRC_SCENE_SCAN) begin
            hs_valid <= (q_scene != '0);
            hs_key   <= q_scene;
            hs_res   <= rec.res;
            hs_tag   <= rec.tag;
            hs_stage <= rec.stage;
          end
          pend_src <= rec_src;
          if (rec_src == SRC_BACKING) begin
            pend_res   <= q_fres;
            pend_tag   <= tag4(q_ftag);
            pend_stage <= q_fstage;
          end else begin
            pend_res   <= rec.res;
            pend_tag   <= tag4(rec.tag);
            pend_stage <= rec.stage;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {7'b0, pend_src, pend_stage, pend_tag, pend_res};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

[design/ktslc_checker.sv]
// Port-level checker for the lookup cache, bound to its top level.
module ktslc_checker
  import ktslc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [23:0]  m_axis_tdata
);

  // A stalled answer keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("answer changed while stalled");

  // Only one item is worked on at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // A null answer is unresolved with no tag and no stage.
  a_null: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16:14] == SRC_NULL |->
      m_axis_tdata[13:0] == {STAGE_NONE, 4'd0, 1'b0})
    else $error("malformed null answer");

endmodule

bind keyed_tag_stage_lookup_cache_unit ktslc_checker u_ktslc_checker (.*);
